@@ design/ekx_pkg.sv @@
`default_nettype none

package ekx_pkg;

	localparam int BYTE_W     = 8;
	localparam int KEY_DEPTH  = 64;
	localparam int KEY_AW     = 6;
	localparam int BANK_DEPTH = KEY_DEPTH / 2;
	localparam int BANK_AW    = KEY_AW - 1;
	localparam int LG_W       = 3;
	localparam int MAX_LG     = 6;
	localparam int LG_RESET   = 2;
	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_AW    = 2;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DATA = 1'b1
	} ekx_op_t;

	typedef struct packed {
		ekx_op_t             operation;
		logic [KEY_AW-1:0]   key_index;
		logic [BYTE_W-1:0]   byte_value;
		logic                end_of_message;
	} ekx_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] result_byte;
		logic              result_last;
	} ekx_out_t;

	typedef struct packed {
		logic               vld;
		logic [BANK_AW-1:0] idx;
		logic [BYTE_W-1:0]  data;
	} ekx_wr_t;

endpackage

`default_nettype wire

@@ design/ekx_item_if.sv @@
`default_nettype none

interface ekx_item_if;
	import ekx_pkg::*;

	logic    valid;
	logic    ready;
	ekx_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ design/ekx_result_if.sv @@
`default_nettype none

interface ekx_result_if;
	import ekx_pkg::*;

	logic     valid;
	logic     ready;
	ekx_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ design/ekx_ram.sv @@
`default_nettype none

module ekx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

@@ design/evolving_key_xor_stream_core.sv @@
// Channel   Role    Handshake     Payload
// item      sink    valid/ready   operation, key_index, byte_value, end_of_message
// result    source  valid/ready   result_byte, result_last
// cfg       write   cfg_wr_en     cfg_wr_data (key_size_log2)
//
// One item per cycle is taken while ready; a data result is registered, then queued.
// Each key store is split into even and odd banks of two-read-port RAM, read in the
// transfer cycle and updated in the following one; the latest update is forwarded.
// Reset clears the byte position, sets key_size_log2 to 2 and clears the per-byte
// modified flags, so the working key reads as the original until a data byte changes it.
// A stalled result sink fills a three-entry result queue; item.ready then falls.

`default_nettype none

module evolving_key_xor_stream_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [ekx_pkg::LG_W-1:0]  cfg_wr_data,
	ekx_item_if.sink                       item,
	ekx_result_if.source                   result
);
	import ekx_pkg::*;

	logic [LG_W-1:0]   lg_q;
	logic [LG_W-1:0]   lg_eff;
	logic [KEY_AW-1:0] key_mask;
	logic              lg_nz;

	logic [KEY_AW-1:0] pos_q;
	logic [KEY_AW-1:0] nxt_a0, nxt_a1, nxt_a3;
	logic              accept;

	logic              valid_s1;
	ekx_in_t           item_s1;
	logic [KEY_AW-1:0] a0_s1, a1_s1, a2_s1, a3_s1;

	logic [KEY_DEPTH-1:0] dirty_q;

	logic [BANK_AW-1:0] raddr_a [2];
	logic [BANK_AW-1:0] raddr_b [2];
	logic [BYTE_W-1:0]  wk_rd_a [2];
	logic [BYTE_W-1:0]  wk_rd_b [2];
	logic [BYTE_W-1:0]  og_rd_a [2];
	logic [BYTE_W-1:0]  og_rd_b [2];

	ekx_wr_t wk_wr [2];
	ekx_wr_t og_wr [2];
	ekx_wr_t wk_fw_q [2];
	ekx_wr_t og_fw_q [2];

	logic [BYTE_W-1:0] w0, w1, w3;
	logic              data_s1, load_s1;
	ekx_out_t          res_s1;

	ekx_out_t           fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q, cnt_q;
	logic [FIFO_AW:0]   occ;
	logic               push, pop;

	function automatic logic [BYTE_W-1:0] key_pick(
		input logic [KEY_AW-1:0] addr,
		input logic              modified,
		input logic [BYTE_W-1:0] wk_raw,
		input logic [BYTE_W-1:0] og_raw,
		input ekx_wr_t           wk_fw,
		input ekx_wr_t           og_fw
	);
		logic [BYTE_W-1:0] wk_val;
		logic [BYTE_W-1:0] og_val;
		wk_val = (wk_fw.vld && wk_fw.idx == addr[KEY_AW-1:1]) ? wk_fw.data : wk_raw;
		og_val = (og_fw.vld && og_fw.idx == addr[KEY_AW-1:1]) ? og_fw.data : og_raw;
		return modified ? wk_val : og_val;
	endfunction

	function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
		return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign lg_eff   = (lg_q > LG_W'(MAX_LG)) ? LG_W'(MAX_LG) : lg_q;
	assign key_mask = ~({KEY_AW{1'b1}} << lg_eff);
	assign lg_nz    = (lg_eff != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= LG_W'(LG_RESET);
		end else if (cfg_wr_en) begin
			lg_q <= cfg_wr_data;
		end
	end

	assign occ        = {1'b0, cnt_q} + {{FIFO_AW{1'b0}}, data_s1};
	assign item.ready = (occ < (FIFO_AW + 1)'(FIFO_DEPTH));
	assign accept     = item.valid && item.ready;

	assign nxt_a0 = pos_q & key_mask;
	assign nxt_a1 = (pos_q + KEY_AW'(1)) & key_mask;
	assign nxt_a3 = (pos_q + KEY_AW'(3)) & key_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && item.data.operation == OP_DATA) begin
			pos_q <= item.data.end_of_message ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item.data;
			a0_s1   <= nxt_a0;
			a1_s1   <= nxt_a1;
			a2_s1   <= (pos_q + KEY_AW'(2)) & key_mask;
			a3_s1   <= nxt_a3;
		end
	end

	for (genvar b = 0; b < 2; b++) begin : g_bank
		assign raddr_a[b] = (nxt_a1[0] == 1'(b)) ? nxt_a1[KEY_AW-1:1] : nxt_a0[KEY_AW-1:1];
		assign raddr_b[b] = nxt_a3[KEY_AW-1:1];

		ekx_ram #(
			.WIDTH (BYTE_W),
			.DEPTH (BANK_DEPTH)
		) u_wk_ram (
			.clk     (clk),
			.we      (wk_wr[b].vld),
			.waddr   (wk_wr[b].idx),
			.wdata   (wk_wr[b].data),
			.raddr_a (raddr_a[b]),
			.raddr_b (raddr_b[b]),
			.rdata_a (wk_rd_a[b]),
			.rdata_b (wk_rd_b[b])
		);

		ekx_ram #(
			.WIDTH (BYTE_W),
			.DEPTH (BANK_DEPTH)
		) u_og_ram (
			.clk     (clk),
			.we      (og_wr[b].vld),
			.waddr   (og_wr[b].idx),
			.wdata   (og_wr[b].data),
			.raddr_a (raddr_a[b]),
			.raddr_b (raddr_b[b]),
			.rdata_a (og_rd_a[b]),
			.rdata_b (og_rd_b[b])
		);

		always_comb begin
			wk_wr[b] = '0;
			og_wr[b] = '0;
			if (data_s1 && a1_s1[0] == 1'(b)) begin
				wk_wr[b].vld  = 1'b1;
				wk_wr[b].idx  = a1_s1[KEY_AW-1:1];
				wk_wr[b].data = w1 ^ w3;
			end else if (data_s1 && lg_nz && a2_s1[0] == 1'(b)) begin
				wk_wr[b].vld  = 1'b1;
				wk_wr[b].idx  = a2_s1[KEY_AW-1:1];
				wk_wr[b].data = w0;
			end
			if (load_s1 && item_s1.key_index[0] == 1'(b)) begin
				og_wr[b].vld  = 1'b1;
				og_wr[b].idx  = item_s1.key_index[KEY_AW-1:1];
				og_wr[b].data = item_s1.byte_value;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				wk_fw_q[b] <= '0;
				og_fw_q[b] <= '0;
			end else begin
				wk_fw_q[b] <= wk_wr[b];
				og_fw_q[b] <= og_wr[b];
			end
		end
	end

	assign data_s1 = valid_s1 && item_s1.operation == OP_DATA;
	assign load_s1 = valid_s1 && item_s1.operation == OP_LOAD;

	assign w0 = key_pick(a0_s1, dirty_q[a0_s1], wk_rd_a[a0_s1[0]], og_rd_a[a0_s1[0]],
		wk_fw_q[a0_s1[0]], og_fw_q[a0_s1[0]]);
	assign w1 = key_pick(a1_s1, dirty_q[a1_s1], wk_rd_a[a1_s1[0]], og_rd_a[a1_s1[0]],
		wk_fw_q[a1_s1[0]], og_fw_q[a1_s1[0]]);
	assign w3 = key_pick(a3_s1, dirty_q[a3_s1], wk_rd_b[a1_s1[0]], og_rd_b[a1_s1[0]],
		wk_fw_q[a3_s1[0]], og_fw_q[a3_s1[0]]);

	// A modified flag selects the working copy; clearing all flags restores the key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
		end else if (data_s1) begin
			if (item_s1.end_of_message) begin
				dirty_q <= '0;
			end else begin
				dirty_q[a1_s1] <= 1'b1;
				if (lg_nz) begin
					dirty_q[a2_s1] <= 1'b1;
				end
			end
		end else if (load_s1) begin
			dirty_q[item_s1.key_index] <= 1'b0;
		end
	end

	assign res_s1.result_byte = item_s1.byte_value ^ w1;
	assign res_s1.result_last = item_s1.end_of_message;

	assign push = data_s1;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_s1;
		end
	end

	assign result.valid = (cnt_q != '0);
	assign result.data  = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ design/ekx_checker.sv @@
`default_nettype none

module ekx_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     item_valid,
	input wire logic                     item_ready,
	input wire ekx_pkg::ekx_op_t         item_op,
	input wire logic                     result_valid,
	input wire logic                     result_ready,
	input wire ekx_pkg::ekx_out_t        result_data
);
	import ekx_pkg::*;

	logic item_xfer;

	assign item_xfer = item_valid && item_ready;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped before its transfer");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("stalled result payload changed");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_xfer && item_op == OP_DATA, 2))
		else $error("result appeared without a data item two cycles earlier");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("item not taken while no result is waiting");

endmodule

bind evolving_key_xor_stream_core ekx_checker u_ekx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_op      (item.data.operation),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

`default_nettype wire
